/* rtl/core/sacta_pkg.sv */
package sacta_pkg;

  // access kinds; both act the same on the tag directory
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // address width of a request
  localparam int ADDR_W = 64;

  // width of the way field of a result
  localparam int WAY_OUT_W = 3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch the request and read its set row
    logic lookup;    // compare tags, pick the way, build the new row
    logic update;    // write the new row back
    logic clear_wr;  // write one zero row during the clearing pass
  } sacta_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last row
  } sacta_status_t;

endpackage

/* rtl/core/set_assoc_cache_tag_aging.sv */
// channel   ports                     handshake
// -------   -----------------------   --------------------------------------
// request   cmd, address              taken when start is high, busy low
// result    hit, way                  one cycle, marked by done
//
// after reset a clearing pass zeroes one set row a cycle, all SETS rows, busy high
// a request goes through row read, tag compare and victim pick, write-back
// done pulses in the write-back step; busy falls the cycle after, so a new request
// is taken only once the last is through, set by the read-modify-write of the single-write-port row memory
// results cannot be stalled; cmd does not change the directory behavior
module set_assoc_cache_tag_aging #(
  parameter int SETS        = 128,
  parameter int WAYS        = 8,
  parameter int OFFSET_BITS = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            cmd,
  input  logic [sacta_pkg::ADDR_W-1:0]    address,
  output logic                            busy,
  output logic                            done,
  output logic                            hit,
  output logic [sacta_pkg::WAY_OUT_W-1:0] way
);

  sacta_pkg::sacta_cmd_t    ctl_cmd;
  sacta_pkg::sacta_status_t dp_status;

  // sequencer
  sacta_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .status  (dp_status),
    .cmd_out (ctl_cmd),
    .busy    (busy),
    .done    (done)
  );

  // tag directory
  sacta_dpath #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (ctl_cmd),
    .address (address),
    .status  (dp_status),
    .hit     (hit),
    .way     (way)
  );

  // each accepted request gives its result, marked by done
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == sacta_pkg::CMD_READ || cmd == sacta_pkg::CMD_WRITE))
      |-> ##2 done)
    else $error("request did not complete in three cycles");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // busy while a result is shown
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  // a strobe is always preceded by an accepted request
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without request");

endmodule

/* rtl/core/sacta_ctrl.sv */
module sacta_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  sacta_pkg::sacta_status_t status,
  output sacta_pkg::sacta_cmd_t    cmd_out,
  output logic                     busy,
  output logic                     done
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // datapath commands
  always_comb begin
    cmd_out.accept   = (state == ST_IDLE) && start;
    cmd_out.lookup   = (state == ST_LOOKUP);
    cmd_out.update   = (state == ST_UPDATE);
    cmd_out.clear_wr = (state == ST_CLEAR);
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_UPDATE);

endmodule

/* rtl/core/sacta_dpath.sv */
module sacta_dpath #(
  parameter int SETS        = 128,
  parameter int WAYS        = 8,
  parameter int OFFSET_BITS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sacta_pkg::sacta_cmd_t               cmd_in,
  input  logic [sacta_pkg::ADDR_W-1:0]        address,
  output sacta_pkg::sacta_status_t            status,
  output logic                                hit,
  output logic [sacta_pkg::WAY_OUT_W-1:0]     way
);

  localparam int SET_W   = $clog2(SETS);
  localparam int TAG_W   = sacta_pkg::ADDR_W - OFFSET_BITS - SET_W;
  localparam int AGE_W   = $clog2(WAYS + 1);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int ENTRY_W = 1 + TAG_W + AGE_W;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam int LVL     = $clog2(WAYS);
  localparam int LEAVES  = 1 << LVL;

  localparam logic [AGE_W-1:0] AGE_FULL = AGE_W'(WAYS);
  localparam logic [AGE_W-1:0] AGE_ONE  = AGE_W'(1);

  // one row per set: each way holds {valid, tag, age}
  logic [ROW_W-1:0] mem [SETS];

  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] new_row;
  logic [ROW_W-1:0] upd_row;
  logic [TAG_W-1:0] req_tag;
  logic [SET_W-1:0] req_set;
  logic [SET_W-1:0] clr_cnt;

  logic [SET_W-1:0] set_field;
  logic [SET_W-1:0] set_in;

  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;

  logic [WAYS-1:0]  way_valid;
  logic [TAG_W-1:0] way_tag [WAYS];
  logic [AGE_W-1:0] way_age [WAYS];
  logic [WAYS-1:0]  hit_vec;
  logic [WAY_W-1:0] hit_idx;
  logic             any_hit;
  logic [WAY_W-1:0] chosen;

  logic [AGE_W-1:0] node_age [2*LEAVES];
  logic [WAY_W-1:0] node_idx [2*LEAVES];

  // set index, folded once when the set count is not a power of two
  assign set_field = address[OFFSET_BITS +: SET_W];
  assign set_in    = ({1'b0, set_field} >= (SET_W + 1)'(SETS)) ?
                     SET_W'(set_field - SET_W'(SETS)) : set_field;

  // latch the request and read its row
  always_ff @(posedge clk) begin
    if (cmd_in.accept) begin
      rd_row  <= mem[set_in];
      req_set <= set_in;
      req_tag <= address[OFFSET_BITS + SET_W +: TAG_W];
    end
  end

  // unpack the row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = rd_row[w*ENTRY_W + TAG_W + AGE_W];
      way_tag[w]   = rd_row[w*ENTRY_W + AGE_W +: TAG_W];
      way_age[w]   = rd_row[w*ENTRY_W +: AGE_W];
      hit_vec[w]   = way_valid[w] && (way_tag[w] == req_tag);
    end
  end

  // lowest matching way
  always_comb begin
    hit_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WAY_W'(w);
      end
    end
  end
  assign any_hit = |hit_vec;

  // minimum-age tree, ties go to the lower way
  always_comb begin
    for (int n = 0; n < LEAVES; n++) begin
      if (n < WAYS) begin
        node_age[LEAVES + n] = way_age[n];
      end else begin
        node_age[LEAVES + n] = '1;
      end
      node_idx[LEAVES + n] = WAY_W'(n);
    end
    node_age[0] = '0;
    node_idx[0] = '0;
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (node_age[2*n] <= node_age[2*n + 1]) begin
        node_age[n] = node_age[2*n];
        node_idx[n] = node_idx[2*n];
      end else begin
        node_age[n] = node_age[2*n + 1];
        node_idx[n] = node_idx[2*n + 1];
      end
    end
  end

  assign chosen = any_hit ? hit_idx : node_idx[1];

  // updated row: used way refreshed, others age toward one
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == chosen) begin
        new_row[w*ENTRY_W +: ENTRY_W] = {1'b1, req_tag, AGE_FULL};
      end else if (way_age[w] > AGE_ONE) begin
        new_row[w*ENTRY_W +: ENTRY_W] = {way_valid[w], way_tag[w], way_age[w] - AGE_ONE};
      end else begin
        new_row[w*ENTRY_W +: ENTRY_W] = {way_valid[w], way_tag[w], way_age[w]};
      end
    end
  end

  // result and write-back row
  always_ff @(posedge clk) begin
    if (cmd_in.lookup) begin
      upd_row <= new_row;
      hit     <= any_hit;
      way     <= sacta_pkg::WAY_OUT_W'(chosen);
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd_in.clear_wr) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end
  assign status.clear_last = (clr_cnt == SET_W'(SETS - 1));

  // single write port
  always_comb begin
    wr_en   = cmd_in.clear_wr || cmd_in.update;
    wr_addr = cmd_in.clear_wr ? clr_cnt : req_set;
    wr_data = cmd_in.clear_wr ? '0 : upd_row;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
